### src/lrst_pkg.sv
package lrst_pkg;

  // default sizes
  localparam int DEF_SLOTS      = 12;
  localparam int DEF_TEMP_COUNT = 7;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_STAMP_BITS = 32;

  // field widths of the request and result beats
  localparam int KIND_W = 2;
  localparam int KEY_W  = 32;
  localparam int REG_W  = 5;
  localparam int STAT_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TEMP    = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // register number tied to each slot, unlisted slots map to register 0
  localparam logic [REG_W-1:0] SLOT_REG_TBL [32] = '{
    0: 5'd8,  1: 5'd9,  2: 5'd18, 3: 5'd19, 4: 5'd20,  5: 5'd21,
    6: 5'd22, 7: 5'd23, 8: 5'd24, 9: 5'd25, 10: 5'd26, 11: 5'd27,
    default: 5'd0
  };

  // temporary registers handed out round-robin
  localparam logic [REG_W-1:0] TEMP_REG_TBL [32] = '{
    0: 5'd5, 1: 5'd6, 2: 5'd7, 3: 5'd28, 4: 5'd29, 5: 5'd30, 6: 5'd31,
    default: 5'd0
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [REG_W-1:0]  reg_num;
  } lrst_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [REG_W-1:0]  reg_out;
    logic              has_space;
    logic [REG_W-1:0]  victim_reg;
    logic              victim_valid;
    logic [KEY_W-1:0]  victim_key;
  } lrst_out_t;

  // control part of the token that walks down the cell chain
  typedef struct packed {
    logic              active;
    logic [KIND_W-1:0] kind;
    logic [REG_W-1:0]  reg_num;
    logic              claimed;
    logic [REG_W-1:0]  reg_out;
    logic              space;
    logic [REG_W-1:0]  vic_reg;
    logic              vic_valid;
  } lrst_tok_t;

endpackage

### src/lrst_cell.sv
module lrst_cell import lrst_pkg::*; #(
  parameter int IDX     = 0,
  parameter int KEY_W   = 32,
  parameter int STAMP_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lrst_tok_t          tok_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [STAMP_W-1:0] nstamp_i,
  input  logic [STAMP_W-1:0] mstamp_i,
  input  logic [KEY_W-1:0]   vkey_i,
  output lrst_tok_t          tok_o,
  output logic [KEY_W-1:0]   key_o,
  output logic [STAMP_W-1:0] nstamp_o,
  output logic [STAMP_W-1:0] mstamp_o,
  output logic [KEY_W-1:0]   vkey_o
);

  localparam logic [REG_W-1:0] MY_REG   = SLOT_REG_TBL[IDX];
  localparam bit               IS_FIRST = (IDX == 0);

  logic               valid_r, valid_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  lrst_tok_t          tok_r, tok_nxt;
  logic [KEY_W-1:0]   tkey_r;
  logic [STAMP_W-1:0] nstamp_r;
  logic [STAMP_W-1:0] mstamp_r, mstamp_nxt;
  logic [KEY_W-1:0]   vkey_r, vkey_nxt;
  logic               hit, rel, take;

  // claim this slot or release it
  always_comb begin
    hit = tok_i.active && !tok_i.claimed &&
          (((tok_i.kind == KIND_ALLOC) && !valid_r) ||
           ((tok_i.kind == KIND_LOOKUP) && valid_r && (key_r == key_i)));
    rel = tok_i.active && (tok_i.kind == KIND_RELEASE) && (tok_i.reg_num == MY_REG);
  end

  // slot contents after this beat
  always_comb begin
    valid_nxt = valid_r;
    stamp_nxt = stamp_r;
    key_nxt   = key_r;
    if (hit) begin
      valid_nxt = 1'b1;
      stamp_nxt = nstamp_i;
      if (tok_i.kind == KIND_ALLOC) begin
        key_nxt = key_i;
      end
    end else if (rel) begin
      valid_nxt = 1'b0;
      stamp_nxt = '0;
    end
  end

  // fold this slot into the running victim and space search
  always_comb begin
    take       = IS_FIRST || (stamp_nxt < mstamp_i);
    tok_nxt    = tok_i;
    mstamp_nxt = mstamp_i;
    vkey_nxt   = vkey_i;
    if (hit) begin
      tok_nxt.claimed = 1'b1;
      tok_nxt.reg_out = MY_REG;
    end
    if (!valid_nxt) begin
      tok_nxt.space = 1'b1;
    end
    if (take) begin
      tok_nxt.vic_reg   = MY_REG;
      tok_nxt.vic_valid = valid_nxt;
      mstamp_nxt        = stamp_nxt;
      vkey_nxt          = key_nxt;
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tkey_r   <= key_i;
    nstamp_r <= nstamp_i;
    mstamp_r <= mstamp_nxt;
    vkey_r   <= vkey_nxt;
  end

  assign tok_o    = tok_r;
  assign key_o    = tkey_r;
  assign nstamp_o = nstamp_r;
  assign mstamp_o = mstamp_r;
  assign vkey_o   = vkey_r;

endmodule

### src/lru_register_slot_table.sv
// channel   | ports                      | handshake
// ----------+----------------------------+-------------------------------------
// request   | start, busy, in_data       | beat taken when start && !busy
// result    | out_valid, out_data        | one-cycle strobe, no back-pressure
//
// A request beat enters the first slot cell in the cycle it is taken and
// moves one cell per cycle down the chain of SLOTS registered cells; the
// result strobe is driven from the token register of the last cell.
// busy stays high from the request edge through the result strobe.
// Synchronous active-low reset clears all slots, the stamp counter and the
// temporary index; the result side cannot stall.
module lru_register_slot_table import lrst_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int TEMP_COUNT = DEF_TEMP_COUNT,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lrst_in_t  in_data,
  output logic      out_valid,
  output lrst_out_t out_data
);

  localparam int SKEY_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int TIDX_W = (TEMP_COUNT > 1) ? $clog2(TEMP_COUNT) : 1;
  localparam logic [TIDX_W-1:0] TIDX_LAST = TIDX_W'(TEMP_COUNT - 1);

  logic                  busy_r, busy_nxt;
  logic [STAMP_BITS-1:0] stamp_ctr_r, stamp_ctr_nxt;
  logic [TIDX_W-1:0]     temp_idx_r, temp_idx_nxt;
  logic                  acc;

  lrst_tok_t             tok    [SLOTS+1];
  logic [SKEY_W-1:0]     tkey   [SLOTS+1];
  logic [STAMP_BITS-1:0] nstamp [SLOTS+1];
  logic [STAMP_BITS-1:0] mstamp [SLOTS+1];
  logic [SKEY_W-1:0]     vkey   [SLOTS+1];
  lrst_tok_t             last;

  assign acc  = start && !busy_r;
  assign busy = busy_r;
  assign last = tok[SLOTS];

  // token that enters the first cell
  always_comb begin
    tok[0]           = '0;
    tok[0].active    = acc;
    tok[0].kind      = in_data.kind;
    tok[0].reg_num   = in_data.reg_num;
    tok[0].reg_out   = (in_data.kind == KIND_TEMP) ? TEMP_REG_TBL[REG_W'(temp_idx_r)] : '0;
    tkey[0]          = in_data.key[SKEY_W-1:0];
    nstamp[0]        = stamp_ctr_r + STAMP_BITS'(1);
    mstamp[0]        = '0;
    vkey[0]          = '0;
  end

  // chain of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lrst_cell #(
      .IDX     (i),
      .KEY_W   (SKEY_W),
      .STAMP_W (STAMP_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok[i]),
      .key_i    (tkey[i]),
      .nstamp_i (nstamp[i]),
      .mstamp_i (mstamp[i]),
      .vkey_i   (vkey[i]),
      .tok_o    (tok[i+1]),
      .key_o    (tkey[i+1]),
      .nstamp_o (nstamp[i+1]),
      .mstamp_o (mstamp[i+1]),
      .vkey_o   (vkey[i+1])
    );
  end

  // busy flag, stamp counter and temporary index
  always_comb begin
    busy_nxt      = busy_r;
    stamp_ctr_nxt = stamp_ctr_r;
    temp_idx_nxt  = temp_idx_r;
    if (acc) begin
      busy_nxt = 1'b1;
      if (in_data.kind == KIND_TEMP) begin
        temp_idx_nxt = (temp_idx_r == TIDX_LAST) ? '0 : temp_idx_r + TIDX_W'(1);
      end
    end
    if (last.active) begin
      busy_nxt = 1'b0;
      if (last.claimed) begin
        stamp_ctr_nxt = nstamp[SLOTS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      stamp_ctr_r <= '0;
      temp_idx_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      stamp_ctr_r <= stamp_ctr_nxt;
      temp_idx_r  <= temp_idx_nxt;
    end
  end

  // result beat from the end of the chain
  always_comb begin
    out_valid             = last.active;
    out_data.status       = ST_OK;
    out_data.reg_out      = last.reg_out;
    out_data.has_space    = last.space;
    out_data.victim_reg   = last.vic_reg;
    out_data.victim_valid = last.vic_valid;
    out_data.victim_key   = last.vic_valid ? KEY_W'(vkey[SLOTS]) : '0;
    case (last.kind)
      KIND_ALLOC:  out_data.status = last.claimed ? ST_OK : ST_FULL;
      KIND_LOOKUP: out_data.status = last.claimed ? ST_OK : ST_MISS;
      default:     out_data.status = ST_OK;
    endcase
  end

endmodule

### src/lrst_checker.sv
module lrst_checker import lrst_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input lrst_out_t out_data
);

  // a result only appears while a request is in flight
  a_out_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat without a request in flight");

  // a taken request raises busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request beat");

  // exactly one result per request, then idle
  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block not idle after result beat");

  // a full table always reports an occupied victim
  a_full_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_space) |-> out_data.victim_valid)
    else $error("full table reported a free victim");

endmodule

bind lru_register_slot_table lrst_checker u_lrst_checker (.*);
